FILE: rtl/psf_pkg.sv
`default_nettype none

package psf_pkg;

  localparam int SLOT_BYTES = 64;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_TOO_LONG = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_BEYOND   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DROP_NONE = 2'd0,
    DROP_FULL = 2'd1,
    DROP_LONG = 2'd2
  } drop_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       is_last;
    logic [5:0] read_index;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] read_byte;
    logic [6:0] head_length;
    logic       is_empty;
    logic       is_full;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/packet_slot_fifo_top.sv
// Packet slot FIFO: a ring of SLOT_COUNT slots of up to SLOT_BYTES bytes each.
// Request channel (req_valid/req_ready/req) carries one operation per item:
// write a byte into the open packet (a last byte commits the slot), read one
// byte of the head slot by index, release the head slot, or clear the ring.
// Response channel (rsp_valid/rsp_ready/rsp) returns exactly one item per
// request: status, read byte, head slot length and the empty/full flags.
// Sequence: an accepted request is registered and executed in the execute state;
// its response is registered once the response register is free, which raises
// rsp_valid. Requests do not overlap: a new one is accepted only after the last
// has passed the sequence read memory, execute and write back, register response,
// around the byte and length memories.
// The response register decouples the channels: a new request is accepted
// while the previous response waits; a stalled receiver holds the next
// response in the execute sequence and blocks further requests.
// Reset clears both pointers, the open-packet byte count and the drop state;
// the slot memories keep their contents and are never cleared.
`default_nettype none

module packet_slot_fifo_top #(
  parameter int SLOT_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  psf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output psf_pkg::rsp_t rsp
);
  import psf_pkg::*;

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LW    = $clog2(SLOT_BYTES + 1);
  localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);

  logic [7:0]    byte_mem [DEPTH];
  logic [LW-1:0] len_mem  [SLOT_COUNT];

  state_t        state, state_next;
  req_t          item;
  logic [SW-1:0] wr_idx, rd_idx, wr_idx_next, rd_idx_next;
  logic          wr_lap, rd_lap, wr_lap_next, rd_lap_next;
  logic [LW-1:0] fill, fill_next;
  drop_t         drop, drop_next;
  status_t       status, status_next;
  logic [7:0]    read_byte, read_byte_next;
  logic [7:0]    byte_q;
  logic [LW-1:0] len_q;

  logic          accept, exec_en, load_rsp;
  logic          empty, full;
  logic          req_in_range, item_in_range, item_beyond_len;
  logic          byte_we, len_we, len_re;
  logic [AW-1:0] byte_waddr, byte_raddr;
  logic [LW-1:0] len_wdata;
  logic [SW-1:0] len_raddr;
  logic [LW+5:0] item_index_ext;
  logic [LW+6:0] head_ext;

  assign accept   = req_valid && req_ready;
  assign exec_en  = (state == S_EXEC);
  assign load_rsp = (state == S_RESP) && (!rsp_valid || rsp_ready);

  assign empty = (wr_idx == rd_idx) && (wr_lap == rd_lap);
  assign full  = (wr_idx == rd_idx) && (wr_lap != rd_lap);

  assign req_in_range   = {{LW{1'b0}}, req.read_index} < (LW + 6)'(SLOT_BYTES);
  assign item_index_ext = {{LW{1'b0}}, item.read_index};
  assign item_in_range  = item_index_ext < (LW + 6)'(SLOT_BYTES);
  assign item_beyond_len = item_index_ext >= {6'b0, len_q};

  assign byte_raddr = AW'(int'(rd_idx) * SLOT_BYTES +
                          (req_in_range ? int'(req.read_index) : 0));
  assign byte_waddr = AW'(int'(wr_idx) * SLOT_BYTES + int'(fill));
  assign len_raddr  = exec_en ? rd_idx_next : rd_idx;
  assign len_re     = accept || exec_en;
  assign head_ext   = {7'b0, len_q};

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= byte_mem[byte_raddr];
    end
    if (byte_we) begin
      byte_mem[byte_waddr] <= item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (len_re) begin
      len_q <= (len_we && (len_raddr == wr_idx)) ? len_wdata : len_mem[len_raddr];
    end
    if (len_we) begin
      len_mem[wr_idx] <= len_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    wr_idx_next    = wr_idx;
    wr_lap_next    = wr_lap;
    rd_idx_next    = rd_idx;
    rd_lap_next    = rd_lap;
    fill_next      = fill;
    drop_next      = drop;
    status_next    = STAT_OK;
    read_byte_next = 8'd0;
    byte_we        = 1'b0;
    len_we         = 1'b0;
    len_wdata      = LW'(fill + 1'b1);
    unique case (item.op)
      OP_WRITE: begin
        if (drop != DROP_NONE) begin
          status_next = (drop == DROP_FULL) ? STAT_FULL : STAT_TOO_LONG;
          if (item.is_last) begin
            drop_next = DROP_NONE;
            fill_next = '0;
          end
        end else if (full) begin
          status_next = STAT_FULL;
          fill_next   = '0;
          if (!item.is_last) begin
            drop_next = DROP_FULL;
          end
        end else if (fill == LW'(SLOT_BYTES)) begin
          status_next = STAT_TOO_LONG;
          fill_next   = '0;
          if (!item.is_last) begin
            drop_next = DROP_LONG;
          end
        end else begin
          byte_we   = exec_en;
          fill_next = LW'(fill + 1'b1);
          if (item.is_last) begin
            len_we    = exec_en;
            fill_next = '0;
            if (wr_idx == LAST_IDX) begin
              wr_idx_next = '0;
              wr_lap_next = !wr_lap;
            end else begin
              wr_idx_next = SW'(wr_idx + 1'b1);
            end
          end
        end
      end
      OP_READ: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else if (item_beyond_len || !item_in_range) begin
          status_next = STAT_BEYOND;
        end else begin
          read_byte_next = byte_q;
        end
      end
      OP_RELEASE: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else if (rd_idx == LAST_IDX) begin
          rd_idx_next = '0;
          rd_lap_next = !rd_lap;
        end else begin
          rd_idx_next = SW'(rd_idx + 1'b1);
        end
      end
      OP_CLEAR: begin
        wr_idx_next = '0;
        wr_lap_next = 1'b0;
        rd_idx_next = '0;
        rd_lap_next = 1'b0;
        fill_next   = '0;
        drop_next   = DROP_NONE;
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (exec_en) begin
      status    <= status_next;
      read_byte <= read_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      wr_lap <= 1'b0;
      rd_idx <= '0;
      rd_lap <= 1'b0;
      fill   <= '0;
      drop   <= DROP_NONE;
    end else if (exec_en) begin
      wr_idx <= wr_idx_next;
      wr_lap <= wr_lap_next;
      rd_idx <= rd_idx_next;
      rd_lap <= rd_lap_next;
      fill   <= fill_next;
      drop   <= drop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status      <= status;
      rsp.read_byte   <= read_byte;
      rsp.head_length <= empty ? 7'd0 : head_ext[6:0];
      rsp.is_empty    <= empty;
      rsp.is_full     <= full;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(SLOT_BYTES))
    else $error("open packet byte count exceeds slot size");

  a_drop_no_fill: assert property (@(posedge clk) disable iff (rst)
    (drop != DROP_NONE) |-> (fill == '0))
    else $error("bytes gathered while dropping a packet");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted item not executed");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_empty && rsp.is_full))
    else $error("ring reported empty and full together");

endmodule

`default_nettype wire

FILE: tb/sv/packet_slot_fifo_checker.sv
`default_nettype none

module packet_slot_fifo_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  psf_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  psf_pkg::rsp_t rsp,
  output int            mismatches,
  output int            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import psf_pkg::*;

  localparam int SLOTS = 16;
  localparam int BYTES = 64;

  logic [7:0] slot_data [SLOTS][BYTES];
  logic [6:0] slot_len  [SLOTS];
  logic [4:0] wr_ptr;
  logic [4:0] rd_ptr;
  logic [6:0] fill;
  drop_t      drop_mode;

  rsp_t due_replies[$];
  int   fail_cnt;

  function automatic logic ring_empty();
    return wr_ptr == rd_ptr;
  endfunction

  function automatic logic ring_full();
    return (wr_ptr[3:0] == rd_ptr[3:0]) && (wr_ptr != rd_ptr);
  endfunction

  task automatic step_ring(input req_t r, output rsp_t e);
    logic [3:0] ws;
    logic [3:0] rs;
    e = '0;
    e.status = STAT_OK;
    ws = wr_ptr[3:0];
    rs = rd_ptr[3:0];
    case (r.op)
      OP_WRITE: begin
        if (drop_mode != DROP_NONE) begin
          if (drop_mode == DROP_FULL) e.status = STAT_FULL;
          else e.status = STAT_TOO_LONG;
          if (r.is_last) begin
            drop_mode = DROP_NONE;
            fill = '0;
          end
        end else if (ring_full()) begin
          e.status = STAT_FULL;
          fill = '0;
          if (!r.is_last) drop_mode = DROP_FULL;
        end else if (fill >= BYTES) begin
          e.status = STAT_TOO_LONG;
          fill = '0;
          if (!r.is_last) drop_mode = DROP_LONG;
        end else begin
          slot_data[ws][fill[5:0]] = r.data_byte;
          fill = fill + 7'd1;
          if (r.is_last) begin
            slot_len[ws] = fill;
            wr_ptr = wr_ptr + 5'd1;
            fill = '0;
          end
        end
      end
      OP_READ: begin
        if (ring_empty()) begin
          e.status = STAT_EMPTY;
        end else if ({1'b0, r.read_index} >= slot_len[rs]) begin
          e.status = STAT_BEYOND;
        end else begin
          e.read_byte = slot_data[rs][r.read_index];
        end
      end
      OP_RELEASE: begin
        if (ring_empty()) e.status = STAT_EMPTY;
        else rd_ptr = rd_ptr + 5'd1;
      end
      default: begin
        wr_ptr = '0;
        rd_ptr = '0;
        fill = '0;
        drop_mode = DROP_NONE;
      end
    endcase
    if (!ring_empty()) e.head_length = slot_len[rd_ptr[3:0]];
    e.is_empty = ring_empty();
    e.is_full  = ring_full();
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t pred;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_len[s] = '0;
        for (int b = 0; b < BYTES; b++) slot_data[s][b] = '0;
      end
      wr_ptr = '0;
      rd_ptr = '0;
      fill = '0;
      drop_mode = DROP_NONE;
      due_replies.delete();
      fail_cnt = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_replies.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected reply: status=%0d byte=%02h len=%0d empty=%0b full=%0b",
                     rsp.status, rsp.read_byte, rsp.head_length, rsp.is_empty, rsp.is_full);
        end else begin
          want = due_replies.pop_front();
          if (rsp.status !== want.status || rsp.read_byte !== want.read_byte ||
              rsp.head_length !== want.head_length || rsp.is_empty !== want.is_empty ||
              rsp.is_full !== want.is_full) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("reply mismatch: exp status=%0d byte=%02h len=%0d empty=%0b full=%0b",
                       want.status, want.read_byte, want.head_length, want.is_empty,
                       want.is_full);
              $display("                got status=%0d byte=%02h len=%0d empty=%0b full=%0b",
                       rsp.status, rsp.read_byte, rsp.head_length, rsp.is_empty, rsp.is_full);
            end
          end
        end
      end
      if (req_valid && req_ready) begin
        step_ring(req, pred);
        due_replies.push_back(pred);
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= due_replies.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_packet_slot_fifo_top.sv
`default_nettype none

module tb_packet_slot_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psf_pkg::*;

  localparam int IDLE_LIMIT = 400;
  localparam int ITEM_TARGET = 1100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int items_sent = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_wait = 0;
  int next_pause = 300;

  always #6 clk = ~clk;

  packet_slot_fifo_top uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  packet_slot_fifo_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic int pick_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic issue(input op_t op, input logic [7:0] b, input logic lst,
                       input logic [5:0] idx);
    req_t item;
    int gap;
    item.op = op;
    item.data_byte = b;
    item.is_last = lst;
    item.read_index = idx;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  task automatic issue_any(input op_t op);
    issue(op, 8'($urandom), 1'($urandom), 6'($urandom));
  endtask

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++)
      issue(OP_WRITE, 8'($urandom), (i == len - 1), 6'($urandom));
  endtask

  task automatic read_head(input logic [5:0] idx);
    issue(OP_READ, 8'($urandom), 1'($urandom), idx);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 63);
    if (r < 95) return 64;
    return $urandom_range(65, 70);
  endfunction

  task automatic run_episode();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_packet(pick_len());
    end else if (r < 55) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 9) < 7) read_head(6'($urandom_range(0, 9)));
        else read_head(6'($urandom));
      end
    end else if (r < 70) begin
      n = $urandom_range(1, 2);
      repeat (n) issue_any(OP_RELEASE);
    end else if (r < 77) begin
      n = $urandom_range(14, 20);
      repeat (n) send_packet($urandom_range(1, 4));
      send_packet($urandom_range(2, 5));
    end else if (r < 82) begin
      n = $urandom_range(8, 20);
      repeat (n) issue_any(OP_RELEASE);
    end else if (r < 86) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) issue(OP_WRITE, 8'($urandom), 1'b0, 6'($urandom));
      issue_any(OP_CLEAR);
    end else if (r < 89) begin
      issue_any(OP_CLEAR);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) issue_any(op_t'($urandom_range(0, 3)));
    end
  endtask

  always @(posedge clk) begin
    int w;
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_wait <= 0;
    end else if (rsp_valid && rsp_ready) begin
      w = pick_gap(rx_calm);
      rsp_ready <= (w == 0);
      rx_wait <= w;
    end else if (rx_wait > 0) begin
      rsp_ready <= (rx_wait == 1);
      rx_wait <= rx_wait - 1;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    read_head(6'd0);
    issue(OP_RELEASE, 8'hFF, 1'b1, 6'h3F);
    issue(OP_CLEAR, 8'h00, 1'b0, 6'h00);
    issue(OP_WRITE, 8'h00, 1'b1, 6'h3F);
    read_head(6'd0);
    read_head(6'd1);
    read_head(6'd63);
    issue(OP_RELEASE, 8'h00, 1'b0, 6'h00);
    issue(OP_WRITE, 8'hFF, 1'b0, 6'h00);
    issue(OP_WRITE, 8'hA5, 1'b1, 6'h3F);
    read_head(6'd1);
    read_head(6'd0);
    issue(OP_CLEAR, 8'hFF, 1'b1, 6'h3F);
    read_head(6'd0);
    issue(OP_WRITE, 8'h5A, 1'b0, 6'h00);
    issue(OP_CLEAR, 8'h00, 1'b0, 6'h00);
    issue(OP_WRITE, 8'h3C, 1'b1, 6'h00);
    read_head(6'd0);
    issue(OP_RELEASE, 8'h00, 1'b0, 6'h00);
    issue(OP_RELEASE, 8'h00, 1'b0, 6'h00);
    wait_drained();

    // fill past full, then overrun a slot with and without a trailing drop
    repeat (17) send_packet($urandom_range(1, 3));
    send_packet(3);
    issue_any(OP_CLEAR);
    send_packet(65);
    send_packet(68);
    send_packet(64);
    read_head(6'd63);
    read_head(6'($urandom));

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_pause) begin
        wait_drained();
        next_pause += 300;
      end
      run_episode();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/psf_pkg.sv
rtl/packet_slot_fifo_top.sv
tb/sv/packet_slot_fifo_checker.sv
tb/sv/tb_packet_slot_fifo_top.sv
